// ----- rtl/core/bmhpq_pkg.sv -----
// types and constants shared by the max-heap priority queue core
// no dependencies
`default_nettype none

package bmhpq_pkg;

  localparam int unsigned OUT_CNT_W = 7;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PEEK   = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        item_tag;
    logic signed [15:0] item_priority;
  } in_beat_t;

  typedef struct packed {
    logic                 accepted;
    logic                 top_valid;
    logic [31:0]          top_tag;
    logic signed [15:0]   top_priority;
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 is_full;
  } out_beat_t;

  typedef struct packed {
    logic [31:0]        tag;
    logic signed [15:0] prio;
  } heap_entry_t;

  typedef struct packed {
    logic load_in;
    logic set_ok;
    logic set_pos_count;
    logic clr_pos;
    logic inc_count;
    logic dec_count;
    logic rd_parent;
    logic rd_last;
    logic rd_kids;
    logic load_entry_rd;
    logic wr_entry;
    logic wr_parent_mv;
    logic wr_child_mv;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic kid_in;
    logic parent_le;
    logic child_gt;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/bmhpq_ctrl.sv -----
// sequencing state machine for heap insert, remove and peek
// depends on bmhpq_pkg
`default_nettype none

module bmhpq_ctrl
  import bmhpq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic [1:0] action,
  input  wire dp_stat_t stat,
  output logic          busy,
  output logic          strobe,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   take;

  assign take = start && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (action == ACT_INSERT && !stat.full) begin
            state_nxt = ST_UP_RD;
          end else if (action == ACT_REMOVE && !stat.empty) begin
            state_nxt = ST_DN_LOAD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_UP_RD:   state_nxt = stat.pos_zero ? ST_DONE : ST_UP_CMP;
      ST_UP_CMP:  state_nxt = stat.parent_le ? ST_UP_RD : ST_DONE;
      ST_DN_LOAD: state_nxt = stat.empty ? ST_DONE : ST_DN_RD;
      ST_DN_RD:   state_nxt = stat.kid_in ? ST_DN_CMP : ST_DONE;
      ST_DN_CMP:  state_nxt = stat.child_gt ? ST_DN_RD : ST_DONE;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    busy   = (state_r != ST_IDLE);
    strobe = (state_r == ST_DONE);
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          cmd.load_in = 1'b1;
          if (action == ACT_INSERT && !stat.full) begin
            cmd.set_ok        = 1'b1;
            cmd.set_pos_count = 1'b1;
          end else if (action == ACT_REMOVE && !stat.empty) begin
            cmd.set_ok    = 1'b1;
            cmd.dec_count = 1'b1;
            cmd.rd_last   = 1'b1;
          end else if (action == ACT_PEEK && !stat.empty) begin
            cmd.set_ok = 1'b1;
          end
        end
      end
      ST_UP_RD: begin
        if (stat.pos_zero) begin
          cmd.wr_entry  = 1'b1;
          cmd.inc_count = 1'b1;
        end else begin
          cmd.rd_parent = 1'b1;
        end
      end
      ST_UP_CMP: begin
        if (stat.parent_le) begin
          cmd.wr_parent_mv = 1'b1;
        end else begin
          cmd.wr_entry  = 1'b1;
          cmd.inc_count = 1'b1;
        end
      end
      ST_DN_LOAD: begin
        if (!stat.empty) begin
          cmd.load_entry_rd = 1'b1;
          cmd.clr_pos       = 1'b1;
        end
      end
      ST_DN_RD: begin
        if (stat.kid_in) begin
          cmd.rd_kids = 1'b1;
        end else begin
          cmd.wr_entry = 1'b1;
        end
      end
      ST_DN_CMP: begin
        if (stat.child_gt) begin
          cmd.wr_child_mv = 1'b1;
        end else begin
          cmd.wr_entry = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/bmhpq_dpath.sv -----
// heap storage, entry count, hole position and result formatting
// depends on bmhpq_pkg
`default_nettype none

module bmhpq_dpath
  import bmhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_beat_t in_data,
  input  wire dp_cmd_t  cmd,
  output dp_stat_t      stat,
  output out_beat_t     out_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = AW + 2;

  heap_entry_t mem [CAPACITY];

  logic [CW-1:0] count_r;
  logic          ok_r;
  logic [AW-1:0] pos_r;
  heap_entry_t   entry_r;
  heap_entry_t   root_r;
  heap_entry_t   rd0_q, rd1_q;

  logic [AW-1:0] parent_idx;
  logic [KW-1:0] kid, kid1, cnt_ext;
  logic          right_ok, right_sel;
  heap_entry_t   child;
  logic [AW-1:0] child_idx;
  logic          we;
  heap_entry_t   wdata;
  logic [AW-1:0] rd0_addr;

  assign parent_idx = AW'((pos_r - AW'(1)) >> 1);
  assign kid        = KW'({pos_r, 1'b1});
  assign kid1       = kid + KW'(1);
  assign cnt_ext    = KW'(count_r);
  assign right_ok   = (kid1 < cnt_ext);
  assign right_sel  = right_ok && ($signed(rd0_q.prio) < $signed(rd1_q.prio));
  assign child      = right_sel ? rd1_q : rd0_q;
  assign child_idx  = right_sel ? kid1[AW-1:0] : kid[AW-1:0];

  assign stat.full      = (count_r == CW'(CAPACITY));
  assign stat.empty     = (count_r == '0);
  assign stat.pos_zero  = (pos_r == '0);
  assign stat.kid_in    = (kid < cnt_ext);
  assign stat.parent_le = ($signed(rd0_q.prio) <= $signed(entry_r.prio));
  assign stat.child_gt  = ($signed(entry_r.prio) < $signed(child.prio));

  assign we = cmd.wr_entry || cmd.wr_parent_mv || cmd.wr_child_mv;

  always_comb begin
    wdata = entry_r;
    if (cmd.wr_parent_mv) begin
      wdata = rd0_q;
    end else if (cmd.wr_child_mv) begin
      wdata = child;
    end
  end

  always_comb begin
    rd0_addr = kid[AW-1:0];
    if (cmd.rd_parent) begin
      rd0_addr = parent_idx;
    end else if (cmd.rd_last) begin
      rd0_addr = AW'(count_r - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_parent || cmd.rd_last || cmd.rd_kids) begin
      rd0_q <= mem[rd0_addr];
    end
    if (cmd.rd_kids) begin
      rd1_q <= mem[kid1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ok_r    <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        ok_r <= cmd.set_ok;
      end
      if (cmd.inc_count) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dec_count) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      entry_r.tag  <= in_data.item_tag;
      entry_r.prio <= in_data.item_priority;
    end else if (cmd.load_entry_rd) begin
      entry_r <= rd0_q;
    end
    if (cmd.set_pos_count) begin
      pos_r <= AW'(count_r);
    end else if (cmd.clr_pos) begin
      pos_r <= '0;
    end else if (cmd.wr_parent_mv) begin
      pos_r <= parent_idx;
    end else if (cmd.wr_child_mv) begin
      pos_r <= child_idx;
    end
    if (we && pos_r == '0) begin
      root_r <= wdata;
    end
  end

  always_comb begin
    out_data.accepted     = ok_r;
    out_data.top_valid    = !stat.empty;
    out_data.top_tag      = stat.empty ? '0 : root_r.tag;
    out_data.top_priority = stat.empty ? '0 : root_r.prio;
    out_data.entry_count  = OUT_CNT_W'(count_r);
    out_data.is_full      = stat.full;
  end

endmodule

`default_nettype wire

// ----- rtl/core/binary_max_heap_priority_queue_core.sv -----
// bounded binary max-heap of (priority, tag) entries, one action per beat
// peek and refused actions go straight to the result; an emptying remove skips the sift;
// insert sifts up and remove sifts down, each making at most six swaps for 64 entries;
// each level is a read state then a compare-and-write state; busy drops in the cycle after the strobe
// result strobe high for one cycle, receiver cannot stall; sync active-low reset empties the heap
`default_nettype none

module binary_max_heap_priority_queue_core
  import bmhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_beat_t in_data,
  output logic          out_strobe,
  output out_beat_t     out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmhpq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_data.action),
    .stat   (stat),
    .busy   (busy),
    .strobe (out_strobe),
    .cmd    (cmd)
  );

  bmhpq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result beat while idle");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.is_full) |-> out_data.top_valid)
    else $error("full heap reported without top entry");

endmodule

`default_nettype wire
